>>> hdl/rre_pkg.sv
// ----------------------------------------------------------------------------
// rre_pkg: shared types and constants
// Action and command codes, configuration and result records for the
// round-trip time / retransmit timeout estimator.
// ----------------------------------------------------------------------------
package rre_pkg;

	localparam int unsigned TW = 32;

	localparam logic [TW-1:0] MIN_TIMEOUT_RST = 32'd200;
	localparam logic [TW-1:0] MAX_TIMEOUT_RST = 32'd60000;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic CFG_MIN_TIMEOUT = 1'b0;
	localparam logic CFG_MAX_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		ACT_ACK    = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_RETX   = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_SEED    = 3'd1,
		OP_CLEAN   = 3'd2,
		OP_SAMPLE  = 3'd3,
		OP_BACKOFF = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef struct packed {
		op_t          op;
		logic [TW-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [TW-1:0] min_timeout;
		logic [TW-1:0] max_timeout;
	} cfg_t;

	typedef struct packed {
		logic          taken;
		logic [TW-1:0] srtt;
		logic [TW-1:0] rttvar;
		logic [TW-1:0] rto;
		logic          measured;
		logic          tentative;
	} result_t;

endpackage

>>> hdl/rre_front.sv
// ----------------------------------------------------------------------------
// rre_front: input stage
// Accepts items, decodes the action into an estimator command and
// computes the elapsed time of an acknowledge.
// ----------------------------------------------------------------------------
module rre_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [31:0]         send_time,
	input  logic [7:0]          send_count,
	input  logic [31:0]         now_time,
	input  logic [31:0]         sample_rtt,
	input  logic                sample_ambiguous,
	input  logic [31:0]         timeout_at_send,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output rre_pkg::cmd_t       cmd
);
	import rre_pkg::*;

	logic   valid_s1;
	cmd_t   cmd_s1;
	cmd_t   cmd_d;
	logic   accept;

	assign in_ready = !valid_s1 || cmd_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd_d.op    = OP_NONE;
		cmd_d.value = now_time - send_time;
		case (action_t'(action))
			ACT_ACK: begin
				if (send_count == 8'd0) begin
					cmd_d.op = OP_NONE;
				end else if (send_count == 8'd1) begin
					cmd_d.op = OP_CLEAN;
				end else begin
					cmd_d.op = OP_SEED;
				end
			end
			ACT_SAMPLE: begin
				cmd_d.op    = sample_ambiguous ? OP_NONE : OP_SAMPLE;
				cmd_d.value = sample_rtt;
			end
			ACT_RETX: begin
				cmd_d.op    = OP_BACKOFF;
				cmd_d.value = timeout_at_send;
			end
			ACT_CLEAR: begin
				cmd_d.op = OP_CLEAR;
			end
			default: begin
				cmd_d.op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

>>> hdl/rre_queue.sv
// ----------------------------------------------------------------------------
// rre_queue: command queue
// Short FIFO of decoded commands between the input stage and the
// estimator update.
// ----------------------------------------------------------------------------
module rre_queue #(
	parameter int unsigned DEPTH = rre_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  rre_pkg::cmd_t  wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output rre_pkg::cmd_t  rd_cmd
);
	import rre_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign wr_ready = count_q != FULL;
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

>>> hdl/rre_back.sv
// ----------------------------------------------------------------------------
// rre_back: estimator update
// Holds SRTT, RTTVAR and RTO, applies one command per cycle while the output
// is not stalled and registers the result item.
// ----------------------------------------------------------------------------
module rre_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rre_pkg::cfg_t     cfg,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  rre_pkg::cmd_t     cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output rre_pkg::result_t  result
);
	import rre_pkg::*;

	function automatic logic [31:0] bound_timeout(input logic [34:0] v,
			input logic [31:0] lo, input logic [31:0] hi);
		logic [34:0] t;
		t = v;
		if (t < {3'b0, lo}) begin
			t = {3'b0, lo};
		end
		if (t > {3'b0, hi}) begin
			t = {3'b0, hi};
		end
		return t[31:0];
	endfunction

	logic        have_q;
	logic        prov_q;
	logic [31:0] srtt_q;
	logic [31:0] rttvar_q;
	logic [31:0] rto_q;
	logic        out_valid_q;
	result_t     res_q;

	logic        fire;
	logic        first;
	logic        blend;
	logic        take;
	logic [31:0] r;
	logic [31:0] err;
	logic [34:0] var_sum;
	logic [34:0] srtt_sum;
	logic [32:0] half_sum;
	logic [31:0] srtt_new;
	logic [31:0] var_new;
	logic [33:0] spread;
	logic [34:0] rto_sum;
	logic [31:0] rto_take;
	logic [31:0] rto_back;

	logic        have_d;
	logic        prov_d;
	logic [31:0] srtt_d;
	logic [31:0] rttvar_d;
	logic [31:0] rto_d;

	assign cmd_ready = !out_valid_q || out_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign r         = cmd.value;

	always_comb begin
		err      = (srtt_q > r) ? srtt_q - r : r - srtt_q;
		var_sum  = {2'b0, rttvar_q, 1'b0} + {3'b0, rttvar_q} + {3'b0, err} + 35'd2;
		srtt_sum = {srtt_q, 3'b0} - {3'b0, srtt_q} + {3'b0, r} + 35'd4;
		half_sum = {1'b0, r} + 33'd1;
		first    = ((cmd.op == OP_SEED) && !have_q)
			|| ((cmd.op == OP_CLEAN) && (!have_q || prov_q))
			|| ((cmd.op == OP_SAMPLE) && !have_q);
		blend    = ((cmd.op == OP_CLEAN) && have_q && !prov_q)
			|| ((cmd.op == OP_SAMPLE) && have_q);
		take     = first || blend;
		srtt_new = first ? r : srtt_sum[34:3];
		var_new  = first ? half_sum[32:1] : var_sum[33:2];
		spread   = {var_new, 2'b0};
		if (spread == '0) begin
			spread = 34'd1;
		end
		rto_sum  = {3'b0, srtt_new} + {1'b0, spread};
		rto_take = bound_timeout(rto_sum, cfg.min_timeout, cfg.max_timeout);
		rto_back = bound_timeout({2'b0, rto_q, 1'b0}, cfg.min_timeout, cfg.max_timeout);

		have_d   = have_q;
		prov_d   = prov_q;
		srtt_d   = srtt_q;
		rttvar_d = rttvar_q;
		rto_d    = rto_q;
		if (take) begin
			have_d   = 1'b1;
			srtt_d   = srtt_new;
			rttvar_d = var_new;
			rto_d    = rto_take;
		end
		case (cmd.op)
			OP_SEED: begin
				if (!have_q) begin
					prov_d = 1'b1;
				end
			end
			OP_CLEAN: begin
				prov_d = 1'b0;
			end
			OP_BACKOFF: begin
				if (have_q && (r >= rto_q)) begin
					rto_d = rto_back;
				end
			end
			OP_CLEAR: begin
				have_d   = 1'b0;
				prov_d   = 1'b0;
				srtt_d   = '0;
				rttvar_d = '0;
				rto_d    = cfg.min_timeout;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			prov_q      <= 1'b0;
			srtt_q      <= '0;
			rttvar_q    <= '0;
			rto_q       <= MIN_TIMEOUT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				have_q      <= have_d;
				prov_q      <= prov_d;
				srtt_q      <= srtt_d;
				rttvar_q    <= rttvar_d;
				rto_q       <= rto_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.taken     <= take;
			res_q.srtt      <= srtt_d;
			res_q.rttvar    <= rttvar_d;
			res_q.rto       <= rto_d;
			res_q.measured  <= have_d;
			res_q.tentative <= prov_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

>>> hdl/rtt_rto_estimator.sv
// ----------------------------------------------------------------------------
// rtt_rto_estimator: round-trip time and retransmit timeout estimator
// Smoothed RTT, RTT variation and clamped, backed-off retransmit timeout
// for one link; retransmitted acknowledgements only seed an empty estimate.
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_ready    action .. timeout_at_send
//   out       output      out_valid/out_ready  taken .. tentative
//   cfg       input       cfg_we               cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; each item is
// registered in the input stage and the command queue before the estimator
// update loads the result register from SRTT/RTTVAR/RTO, which it computes
// combinationally. Reset is immediate, no clearing pass. A stalled output
// backs up into the queue; input is taken until queue and input stage fill.
// ----------------------------------------------------------------------------
module rtt_rto_estimator #(
	parameter int unsigned QUEUE_DEPTH = rre_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] send_time,
	input  logic [7:0]  send_count,
	input  logic [31:0] now_time,
	input  logic [31:0] sample_rtt,
	input  logic        sample_ambiguous,
	input  logic [31:0] timeout_at_send,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        taken,
	output logic [31:0] srtt_out,
	output logic [31:0] rttvar_out,
	output logic [31:0] rto_out,
	output logic        measured,
	output logic        tentative
);
	import rre_pkg::*;

	cfg_t    cfg_q;
	cmd_t    f_cmd;
	logic    f_valid;
	logic    f_ready;
	cmd_t    q_cmd;
	logic    q_valid;
	logic    q_ready;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_timeout <= MIN_TIMEOUT_RST;
			cfg_q.max_timeout <= MAX_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_TIMEOUT: cfg_q.min_timeout <= cfg_data;
				CFG_MAX_TIMEOUT: cfg_q.max_timeout <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rre_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.send_time        (send_time),
		.send_count       (send_count),
		.now_time         (now_time),
		.sample_rtt       (sample_rtt),
		.sample_ambiguous (sample_ambiguous),
		.timeout_at_send  (timeout_at_send),
		.cmd_valid        (f_valid),
		.cmd_ready        (f_ready),
		.cmd              (f_cmd)
	);

	rre_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_cmd   (q_cmd)
	);

	rre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (res)
	);

	assign taken      = res.taken;
	assign srtt_out   = res.srtt;
	assign rttvar_out = res.rttvar;
	assign rto_out    = res.rto;
	assign measured   = res.measured;
	assign tentative  = res.tentative;

endmodule
